// File: src/pwsq_pkg.sv
// Package for the square-to-quad projective warp setup block.
// Types, widths and arithmetic helpers shared by front, queue, back and top.
// No dependencies.
package pwsq_pkg;

  // Fixed-point format of corners and matrix entries
  localparam int FRAC_BITS = 16;

  // Queue between front and back
  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  // Intermediate widths
  localparam int DIFF_W = 33;                 // corner difference
  localparam int SUM_W  = 34;                 // corner sum sx, sy
  localparam int PA_W   = 2 * DIFF_W;         // det partial product
  localparam int PN_W   = SUM_W + DIFF_W;     // numerator partial product
  localparam int DET_W  = PA_W + 1;           // determinant
  localparam int NUM_W  = PN_W + 1;           // g or h numerator
  localparam int DW     = DET_W;              // divisor 2*|det|
  localparam int NW     = NUM_W + FRAC_BITS + 1;  // dividend and quotient
  localparam int GW     = FRAC_BITS + 46;     // clamped g, h
  localparam int GHW    = GW - 31;            // upper slice of g for the multiply
  localparam int PH_W   = GHW + 32;
  localparam int PL_W   = 64;
  localparam int TW     = GW + 33;            // entry sum before rounding
  localparam int RW     = TW - FRAC_BITS;     // entry after rounding

  localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] SAT_HI = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_LO = 32'sh80000000;
  localparam logic [TW-1:0] HALF_POS = TW'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0] HALF_NEG = HALF_POS - TW'(1);

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;
  } in_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] coef_0;
    logic signed [31:0] coef_1;
    logic signed [31:0] coef_2;
    logic signed [31:0] coef_3;
    logic signed [31:0] coef_4;
    logic signed [31:0] coef_5;
    logic signed [31:0] coef_6;
    logic signed [31:0] coef_7;
    logic signed [31:0] coef_8;
  } out_t;

  // Classified transaction as queued for the back end
  typedef struct packed {
    logic                     bad;
    logic                     affine;
    logic signed [DET_W-1:0]  det;
    logic signed [NUM_W-1:0]  num_g;
    logic signed [NUM_W-1:0]  num_h;
    logic signed [DIFF_W-1:0] e0;
    logic signed [DIFF_W-1:0] e1;
    logic signed [DIFF_W-1:0] e3;
    logic signed [DIFF_W-1:0] e4;
    logic signed [31:0]       c1x;
    logic signed [31:0]       c1y;
    logic signed [31:0]       c2x;
    logic signed [31:0]       c2y;
    logic signed [31:0]       x0;
    logic signed [31:0]       y0;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t data;
  } qpush_t;

  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  // Sideband carried down the back pipeline
  typedef struct packed {
    logic                     bad;
    logic                     affine;
    logic                     neg_g;
    logic                     neg_h;
    logic [DW-1:0]            d;
    logic signed [DIFF_W-1:0] e0;
    logic signed [DIFF_W-1:0] e1;
    logic signed [DIFF_W-1:0] e3;
    logic signed [DIFF_W-1:0] e4;
    logic signed [31:0]       c1x;
    logic signed [31:0]       c1y;
    logic signed [31:0]       c2x;
    logic signed [31:0]       c2y;
    logic signed [31:0]       x0;
    logic signed [31:0]       y0;
  } side_t;

  // Restoring divider state: partial remainder, dividend shifting out, quotient in
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] nq;
  } div_st_t;

  // One restoring division step
  function automatic div_st_t div_step(input div_st_t s, input logic [DW-1:0] d);
    div_st_t     r;
    logic [DW:0] r2;
    logic [DW:0] df;
    r2 = {s.rem, s.nq[NW-1]};
    df = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      r.rem = df[DW-1:0];
      r.nq  = {s.nq[NW-2:0], 1'b1};
    end else begin
      r.rem = r2[DW-1:0];
      r.nq  = {s.nq[NW-2:0], 1'b0};
    end
    return r;
  endfunction

  // Clamp a signed quotient to GW bits; any clamped value still saturates alike
  function automatic logic signed [GW-1:0] clamp_g(input logic signed [NW:0] v);
    logic [NW-GW+1:0] up;
    up = v[NW:GW-1];
    if ((&up) || !(|up)) return v[GW-1:0];
    else if (v[NW]) return {1'b1, {(GW-1){1'b0}}};
    else return {1'b0, {(GW-1){1'b1}}};
  endfunction

  function automatic logic signed [31:0] sat_g(input logic signed [GW-1:0] v);
    logic [GW-32:0] up;
    up = v[GW-1:31];
    if ((&up) || !(|up)) return v[31:0];
    else if (v[GW-1]) return SAT_LO;
    else return SAT_HI;
  endfunction

  function automatic logic signed [31:0] sat_r(input logic signed [RW-1:0] v);
    logic [RW-32:0] up;
    up = v[RW-1:31];
    if ((&up) || !(|up)) return v[31:0];
    else if (v[RW-1]) return SAT_LO;
    else return SAT_HI;
  endfunction

  // Drop FRAC_BITS fraction bits, halves away from zero, then saturate
  function automatic logic signed [31:0] round_sat(input logic signed [TW-1:0] t);
    logic [TW-1:0] s;
    s = t + (t[TW-1] ? HALF_NEG : HALF_POS);
    return sat_r(s[TW-1:FRAC_BITS]);
  endfunction

endpackage

// File: src/projective_warp_square_to_quad_top.sv
// Throughput: one transaction per cycle unless the output register is full and not taken,
// set by the fully pipelined restoring dividers (one quotient bit per stage) and the
// four-entry front-to-back queue.
// Reset: synchronous active-low rst_n clears all valid bits, credits and pointers.
// Depends on pwsq_pkg, pwsq_front, pwsq_fifo and pwsq_back.
module projective_warp_square_to_quad_top import pwsq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  qpush_t q_push;
  qent_t  q_head;
  qstat_t q_stat;
  logic   q_pop;

  // Classify and compute determinant
  pwsq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .pop_i    (q_pop),
    .push_o   (q_push)
  );

  // Decoupling queue
  pwsq_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Divide, multiply, round, saturate
  pwsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_i    (q_head),
    .stat_i    (q_stat),
    .pop_o     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.push |-> (!q_stat.full || q_pop))
    else $error("queue push while full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("queue pop while empty");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |->
      (out_data.coef_0 == '0 && out_data.coef_1 == '0 && out_data.coef_2 == '0 &&
       out_data.coef_3 == '0 && out_data.coef_4 == '0 && out_data.coef_5 == '0 &&
       out_data.coef_6 == '0 && out_data.coef_7 == '0 && out_data.coef_8 == '0))
    else $error("bad warp result carries nonzero entries");

  a_ok_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.status) |-> (out_data.coef_8 == ONE_Q))
    else $error("homogeneous entry is not one");
`endif

endmodule

// File: src/pwsq_front.sv
// Front end: accepts corner transactions, forms differences, products,
// determinant and numerators, classifies, and pushes into the queue. Uses pwsq_pkg.
module pwsq_front import pwsq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  input  logic   pop_i,
  output qpush_t push_o
);

  logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [PA_W-1:0]   pa_nxt, pb_nxt;
  logic signed [PN_W-1:0]   pg1_nxt, pg2_nxt, ph1_nxt, ph2_nxt;
  logic                     acc;

  logic                     v1_r;
  logic signed [PA_W-1:0]   pa_r, pb_r;
  logic signed [PN_W-1:0]   pg1_r, pg2_r, ph1_r, ph2_r;
  logic                     affine_r;
  logic signed [DIFF_W-1:0] e0_r, e1_r, e3_r, e4_r;
  logic signed [31:0]       c1x_r, c1y_r, c2x_r, c2y_r, x0_r, y0_r;
  logic [QCW-1:0]           cnt_r, cnt_nxt;
  logic signed [DET_W-1:0]  det;

  // Credits cover the product stage plus the queue, so the queue never overflows
  assign in_ready = (cnt_r < QCW'(QD));
  assign acc      = in_valid && in_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !pop_i) cnt_nxt = cnt_r + QCW'(1);
    else if (!acc && pop_i) cnt_nxt = cnt_r - QCW'(1);
  end

  // Edge differences and corner sums
  assign dx1 = DIFF_W'(in_data.corner1_x) - DIFF_W'(in_data.corner3_x);
  assign dy1 = DIFF_W'(in_data.corner1_y) - DIFF_W'(in_data.corner3_y);
  assign dx2 = DIFF_W'(in_data.corner2_x) - DIFF_W'(in_data.corner3_x);
  assign dy2 = DIFF_W'(in_data.corner2_y) - DIFF_W'(in_data.corner3_y);
  assign sx  = SUM_W'(in_data.corner0_x) - SUM_W'(in_data.corner1_x)
             + SUM_W'(in_data.corner3_x) - SUM_W'(in_data.corner2_x);
  assign sy  = SUM_W'(in_data.corner0_y) - SUM_W'(in_data.corner1_y)
             + SUM_W'(in_data.corner3_y) - SUM_W'(in_data.corner2_y);

  // Six products for det and the two numerators
  assign pa_nxt  = dx1 * dy2;
  assign pb_nxt  = dx2 * dy1;
  assign pg1_nxt = sx * dy2;
  assign pg2_nxt = dx2 * sy;
  assign ph1_nxt = dx1 * sy;
  assign ph2_nxt = sx * dy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      v1_r  <= acc;
      cnt_r <= cnt_nxt;
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      pg1_r    <= pg1_nxt;
      pg2_r    <= pg2_nxt;
      ph1_r    <= ph1_nxt;
      ph2_r    <= ph2_nxt;
      affine_r <= (sx == '0) && (sy == '0);
      e0_r     <= DIFF_W'(in_data.corner1_x) - DIFF_W'(in_data.corner0_x);
      e1_r     <= DIFF_W'(in_data.corner1_y) - DIFF_W'(in_data.corner0_y);
      e3_r     <= DIFF_W'(in_data.corner2_x) - DIFF_W'(in_data.corner0_x);
      e4_r     <= DIFF_W'(in_data.corner2_y) - DIFF_W'(in_data.corner0_y);
      c1x_r    <= in_data.corner1_x;
      c1y_r    <= in_data.corner1_y;
      c2x_r    <= in_data.corner2_x;
      c2y_r    <= in_data.corner2_y;
      x0_r     <= in_data.corner0_x;
      y0_r     <= in_data.corner0_y;
    end
  end

  // Determinant, numerators and classification go straight into the queue
  assign det = DET_W'(pa_r) - DET_W'(pb_r);

  always_comb begin
    push_o.push        = v1_r;
    push_o.data.bad    = (det == '0);
    push_o.data.affine = affine_r;
    push_o.data.det    = det;
    push_o.data.num_g  = NUM_W'(pg1_r) - NUM_W'(pg2_r);
    push_o.data.num_h  = NUM_W'(ph1_r) - NUM_W'(ph2_r);
    push_o.data.e0     = e0_r;
    push_o.data.e1     = e1_r;
    push_o.data.e3     = e3_r;
    push_o.data.e4     = e4_r;
    push_o.data.c1x    = c1x_r;
    push_o.data.c1y    = c1y_r;
    push_o.data.c2x    = c2x_r;
    push_o.data.c2y    = c2y_r;
    push_o.data.x0     = x0_r;
    push_o.data.y0     = y0_r;
  end

endmodule

// File: src/pwsq_fifo.sv
// Short queue between front and back end, QD entries in flip-flops.
// Uses pwsq_pkg.
module pwsq_fifo import pwsq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qpush_t push_i,
  input  logic   pop_i,
  output qent_t  head_o,
  output qstat_t stat_o
);

  qent_t          mem_r [QD];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign head_o       = mem_r[rd_r];
  assign stat_o.valid = (cnt_r != '0);
  assign stat_o.full  = (cnt_r == QCW'(QD));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i.push && !pop_i) cnt_nxt = cnt_r + QCW'(1);
    else if (!push_i.push && pop_i) cnt_nxt = cnt_r - QCW'(1);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i.push) wr_r <= wr_r + QAW'(1);
      if (pop_i) rd_r <= rd_r + QAW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_i.push) mem_r[wr_r] <= push_i.data;
  end

endmodule

// File: src/pwsq_back.sv
// Back end: pipelined restoring dividers for g and h, entry multiply,
// rounding, saturation and the output register. Uses pwsq_pkg.
module pwsq_back import pwsq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qent_t  head_i,
  input  qstat_t stat_i,
  output logic   pop_o,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  logic en;

  // Operand prep
  logic [DET_W-1:0] adet;
  logic [NUM_W-1:0] anum_g, anum_h;
  div_st_t          st0_g, st0_h;
  side_t            side0;

  // Divider stages, index 0 is the operand register
  logic    v_r      [NW+1];
  div_st_t st_g_r   [NW+1];
  div_st_t st_h_r   [NW+1];
  side_t   side_r   [NW+1];

  // Post-divide stages
  logic signed [NW:0]   qg, qh;
  logic                 vg_r, vp_r, vt_r, out_valid_r;
  logic signed [GW-1:0] g_r, h_r, g2_r, h2_r, g3_r, h3_r;
  side_t                sg_r, sp_r, st_r;
  logic signed [PH_W-1:0] ph_nxt [4];
  logic signed [PL_W-1:0] pl_nxt [4];
  logic signed [PH_W-1:0] ph_r [4];
  logic signed [PL_W-1:0] pl_r [4];
  logic signed [TW-1:0]   t_r  [4];
  logic signed [GW-1:0]   pf   [4];
  logic signed [31:0]     pc   [4];
  logic signed [DIFF_W-1:0] pd [4];
  out_t                   out_r, out_nxt;

  // Whole pipeline stalls only when the output register is full and not taken
  assign en        = !out_valid_r || out_ready;
  assign pop_o     = en && stat_i.valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Operands: dividend |num|*2^(F+1) + |det|, divisor 2*|det|
  always_comb begin
    adet   = head_i.det[DET_W-1] ? DET_W'(-head_i.det) : DET_W'(head_i.det);
    anum_g = head_i.num_g[NUM_W-1] ? NUM_W'(-head_i.num_g) : NUM_W'(head_i.num_g);
    anum_h = head_i.num_h[NUM_W-1] ? NUM_W'(-head_i.num_h) : NUM_W'(head_i.num_h);
    st0_g.rem = '0;
    st0_g.nq  = (NW'(anum_g) << (FRAC_BITS + 1)) + NW'(adet);
    st0_h.rem = '0;
    st0_h.nq  = (NW'(anum_h) << (FRAC_BITS + 1)) + NW'(adet);
    side0.bad    = head_i.bad;
    side0.affine = head_i.affine;
    side0.neg_g  = head_i.num_g[NUM_W-1] ^ head_i.det[DET_W-1];
    side0.neg_h  = head_i.num_h[NUM_W-1] ^ head_i.det[DET_W-1];
    side0.d      = {adet[DET_W-2:0], 1'b0};
    side0.e0     = head_i.e0;
    side0.e1     = head_i.e1;
    side0.e3     = head_i.e3;
    side0.e4     = head_i.e4;
    side0.c1x    = head_i.c1x;
    side0.c1y    = head_i.c1y;
    side0.c2x    = head_i.c2x;
    side0.c2y    = head_i.c2y;
    side0.x0     = head_i.x0;
    side0.y0     = head_i.y0;
  end

  // Valid chain through operand and divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= stat_i.valid;
      for (int k = 1; k <= NW; k++) v_r[k] <= v_r[k-1];
    end
  end

  // One quotient bit per stage for each divider
  always_ff @(posedge clk) begin
    if (en) begin
      st_g_r[0] <= st0_g;
      st_h_r[0] <= st0_h;
      side_r[0] <= side0;
      for (int k = 1; k <= NW; k++) begin
        st_g_r[k] <= div_step(st_g_r[k-1], side_r[k-1].d);
        st_h_r[k] <= div_step(st_h_r[k-1], side_r[k-1].d);
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Signed, clamped g and h; zero in the affine case
  assign qg = side_r[NW].neg_g ? -$signed({1'b0, st_g_r[NW].nq})
                               : $signed({1'b0, st_g_r[NW].nq});
  assign qh = side_r[NW].neg_h ? -$signed({1'b0, st_h_r[NW].nq})
                               : $signed({1'b0, st_h_r[NW].nq});

  // Entry multiplies: g and h each split into a signed upper and an unsigned lower slice
  always_comb begin
    pf[0] = g_r;  pf[1] = g_r;  pf[2] = h_r;  pf[3] = h_r;
    pc[0] = sg_r.c1x; pc[1] = sg_r.c1y; pc[2] = sg_r.c2x; pc[3] = sg_r.c2y;
    for (int i = 0; i < 4; i++) begin
      ph_nxt[i] = $signed(pf[i][GW-1:31]) * pc[i];
      pl_nxt[i] = $signed({1'b0, pf[i][30:0]}) * pc[i];
    end
  end

  always_comb begin
    pd[0] = sp_r.e0; pd[1] = sp_r.e1; pd[2] = sp_r.e3; pd[3] = sp_r.e4;
  end

  // Output assembly: round, saturate, bad warp forces zeros
  always_comb begin
    out_nxt.status = st_r.bad;
    out_nxt.coef_0 = round_sat(t_r[0]);
    out_nxt.coef_1 = round_sat(t_r[1]);
    out_nxt.coef_2 = sat_g(g3_r);
    out_nxt.coef_3 = round_sat(t_r[2]);
    out_nxt.coef_4 = round_sat(t_r[3]);
    out_nxt.coef_5 = sat_g(h3_r);
    out_nxt.coef_6 = st_r.x0;
    out_nxt.coef_7 = st_r.y0;
    out_nxt.coef_8 = ONE_Q;
    if (st_r.bad) begin
      out_nxt        = '0;
      out_nxt.status = 1'b1;
    end
  end

  // Post-divide control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r        <= 1'b0;
      vp_r        <= 1'b0;
      vt_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vg_r        <= v_r[NW];
      vp_r        <= vg_r;
      vt_r        <= vp_r;
      out_valid_r <= vt_r;
    end
  end

  // Post-divide payload
  always_ff @(posedge clk) begin
    if (en) begin
      g_r  <= side_r[NW].affine ? '0 : clamp_g(qg);
      h_r  <= side_r[NW].affine ? '0 : clamp_g(qh);
      sg_r <= side_r[NW];
      g2_r <= g_r;
      h2_r <= h_r;
      sp_r <= sg_r;
      for (int i = 0; i < 4; i++) begin
        ph_r[i] <= ph_nxt[i];
        pl_r[i] <= pl_nxt[i];
      end
      g3_r <= g2_r;
      h3_r <= h2_r;
      st_r <= sp_r;
      for (int i = 0; i < 4; i++) begin
        t_r[i] <= (TW'(pd[i]) <<< FRAC_BITS) + (TW'(ph_r[i]) <<< 31) + TW'(pl_r[i]);
      end
      out_r <= out_nxt;
    end
  end

endmodule

// File: tb/projective_warp_square_to_quad_top_tb.sv
// Testbench for the square-to-quad projective warp setup block.
// Directed rows, then random quads checked against a local matrix predictor.
// Depends on pwsq_pkg and projective_warp_square_to_quad_top.
`timescale 1ns / 1ps

module projective_warp_square_to_quad_top_tb;
  import pwsq_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    in_t  quad;
    bit   typed;
    out_t mat;
  } row_t;

  localparam int RANDOM_QUADS = 900;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * (FRAC_BITS + 75);
  localparam logic signed [31:0] I_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] I_MIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // typed expectation that travels with the driven quad
  bit   in_typed = 1'b0;
  out_t in_mat = '0;

  out_t matrix_q[$];
  row_t rows[$];
  logic in_fire = 1'b0;
  bit   quiet = 1'b0;
  int   mismatches = 0;
  int   idle_cycles = 0;

  projective_warp_square_to_quad_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- matrix predictor ----------------
  function automatic logic signed [31:0] clip32(wide_t v);
    if (v > wide_t'(I_MAX)) return I_MAX;
    if (v < wide_t'(I_MIN)) return I_MIN;
    return v[31:0];
  endfunction

  // num * 2^FRAC_BITS / den, halves away from zero
  function automatic wide_t persp_quot(wide_t num, wide_t den);
    logic [127:0] an, ad, q;
    an = num[127] ? -num : num;
    ad = den[127] ? -den : den;
    q = ((an << (FRAC_BITS + 1)) + ad) / (ad << 1);
    return (num[127] ^ den[127]) ? -wide_t'(q) : wide_t'(q);
  endfunction

  // drop fraction bits, halves away from zero, saturate
  function automatic logic signed [31:0] warp_entry(wide_t diff, wide_t p, wide_t c);
    wide_t t;
    logic [127:0] m;
    t = (diff <<< FRAC_BITS) + p * c;
    m = t[127] ? -t : t;
    m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clip32(t[127] ? -wide_t'(m) : wide_t'(m));
  endfunction

  function automatic out_t warp_matrix(in_t q);
    wide_t x0, y0, x1, y1, x2, y2, x3, y3;
    wide_t dx1, dy1, dx2, dy2, sx, sy, det, g, h;
    out_t r;
    x0 = q.corner0_x; y0 = q.corner0_y;
    x1 = q.corner1_x; y1 = q.corner1_y;
    x2 = q.corner2_x; y2 = q.corner2_y;
    x3 = q.corner3_x; y3 = q.corner3_y;
    dx1 = x1 - x3; dy1 = y1 - y3; dx2 = x2 - x3; dy2 = y2 - y3;
    sx = x0 - x1 + x3 - x2;
    sy = y0 - y1 + y3 - y2;
    det = dx1 * dy2 - dx2 * dy1;
    r = '0;
    if (det == 0) begin
      r.status = 1'b1;
      return r;
    end
    r.coef_6 = q.corner0_x;
    r.coef_7 = q.corner0_y;
    r.coef_8 = ONE_Q;
    if (sx == 0 && sy == 0) begin
      r.coef_0 = clip32(x1 - x0);
      r.coef_1 = clip32(y1 - y0);
      r.coef_3 = clip32(x3 - x1);
      r.coef_4 = clip32(y3 - y1);
      return r;
    end
    g = persp_quot(sx * dy2 - dx2 * sy, det);
    h = persp_quot(dx1 * sy - sx * dy1, det);
    r.coef_0 = warp_entry(x1 - x0, g, x1);
    r.coef_1 = warp_entry(y1 - y0, g, y1);
    r.coef_2 = clip32(g);
    r.coef_3 = warp_entry(x2 - x0, h, x2);
    r.coef_4 = warp_entry(y2 - y0, h, y2);
    r.coef_5 = clip32(h);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic in_t mk_quad(int a, int b, int c, int d, int e, int f, int g, int h);
    in_t q;
    q.corner0_x = a; q.corner0_y = b;
    q.corner1_x = c; q.corner1_y = d;
    q.corner2_x = e; q.corner2_y = f;
    q.corner3_x = g; q.corner3_y = h;
    return q;
  endfunction

  function automatic out_t mk_mat(bit st, int c0, int c1, int c3, int c4, int c6, int c7);
    out_t r;
    r = '0;
    r.status = st;
    r.coef_0 = c0; r.coef_1 = c1; r.coef_3 = c3; r.coef_4 = c4;
    r.coef_6 = c6; r.coef_7 = c7;
    r.coef_8 = st ? 32'sd0 : ONE_Q;
    return r;
  endfunction

  function automatic int edge_val();
    case ($urandom_range(0, 5))
      0: return I_MAX;
      1: return I_MIN;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int near(int base, int spread);
    return base + $urandom_range(0, 2 * spread) - spread;
  endfunction

  function automatic in_t random_quad();
    int bx, by, s, kx, ky;
    in_t q;
    bx = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    by = int'($urandom_range(0, 1 << 22)) - (1 << 21);
    s  = $urandom_range(1, 1 << 20);
    case ($urandom_range(0, 9))
      0, 1: q = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
      2, 3, 4, 5: begin
        // perturbed square: perspective
        q = mk_quad(near(bx, s / 4), near(by, s / 4),
                    near(bx + s, s / 4), near(by, s / 4),
                    near(bx, s / 4), near(by + s, s / 4),
                    near(bx + s, s / 4), near(by + s, s / 4));
      end
      6, 7: begin
        // parallelogram: affine
        q.corner0_x = near(bx, 1 << 24); q.corner0_y = near(by, 1 << 24);
        q.corner1_x = near(bx, 1 << 24); q.corner1_y = near(by, 1 << 24);
        q.corner2_x = near(bx, 1 << 24); q.corner2_y = near(by, 1 << 24);
        q.corner3_x = q.corner1_x + q.corner2_x - q.corner0_x;
        q.corner3_y = q.corner1_y + q.corner2_y - q.corner0_y;
      end
      8: begin
        // all corners on one line: zero determinant
        kx = near(0, 1 << 10); ky = near(0, 1 << 10);
        q = mk_quad(bx, by, bx + kx * 3, by + ky * 3,
                    bx - kx * 7, by - ky * 7, bx + kx * 11, by + ky * 11);
      end
      default: q = mk_quad(edge_val(), edge_val(), edge_val(), edge_val(),
                           edge_val(), edge_val(), edge_val(), edge_val());
    endcase
    return q;
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 24);
  endfunction

  // ---------------- acceptance, checking, watchdog ----------------
  always @(posedge clk) begin
    logic signed [31:0] want, got;
    out_t exp_mat;
    in_fire <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      matrix_q.push_back(in_typed ? in_mat : warp_matrix(in_data));
    end
    if (rst_n && out_valid && out_ready) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", out_data);
      end else begin
        exp_mat = matrix_q.pop_front();
        if (exp_mat.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("status mismatch: exp %0b got %0b", exp_mat.status, out_data.status);
        end
        for (int i = 0; i < 9; i++) begin
          want = exp_mat[32 * (8 - i) +: 32];
          got  = out_data[32 * (8 - i) +: 32];
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("coef_%0d mismatch: exp %08h got %08h", i, want, got);
          end
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= rst_n && !idle_now();
  end

  // ---------------- main sequence ----------------
  initial begin
    row_t r;
    // directed table
    r.typed = 1'b1;
    r.quad = mk_quad(0, 0, 0, 0, 0, 0, 0, 0); r.mat = mk_mat(1, 0, 0, 0, 0, 0, 0);
    rows.push_back(r);
    r.quad = {8{I_MAX}}; r.mat = mk_mat(1, 0, 0, 0, 0, 0, 0);
    rows.push_back(r);
    r.quad = {8{I_MIN}}; r.mat = mk_mat(1, 0, 0, 0, 0, 0, 0);
    rows.push_back(r);
    r.quad = mk_quad(0, 0, ONE_Q, 0, 0, ONE_Q, ONE_Q, ONE_Q);
    r.mat = mk_mat(0, ONE_Q, 0, 0, ONE_Q, 0, 0);
    rows.push_back(r);
    r.quad = mk_quad(I_MIN, 0, I_MAX, 0, I_MIN, 1, I_MAX, 1);
    r.mat = mk_mat(0, I_MAX, 0, 0, 1, I_MIN, 0);
    rows.push_back(r);
    r.quad = mk_quad(I_MAX, -1, I_MIN, -1, I_MAX, 0, I_MIN, 0);
    r.mat = mk_mat(0, I_MIN, 0, 0, 1, I_MAX, -1);
    rows.push_back(r);
    r.typed = 1'b0;
    r.quad = mk_quad(0, 0, 2 * ONE_Q, 0, ONE_Q / 2, ONE_Q, 3 * ONE_Q / 2, ONE_Q);
    rows.push_back(r);
    r.quad = mk_quad(-5 * ONE_Q, -3 * ONE_Q, 7 * ONE_Q, -ONE_Q,
                     -2 * ONE_Q, 9 * ONE_Q, 4 * ONE_Q, 6 * ONE_Q);
    rows.push_back(r);
    r.quad = mk_quad(0, 0, 1, 0, 0, 1, 2, 3);
    rows.push_back(r);
    r.quad = mk_quad(I_MAX, I_MIN, I_MIN, I_MAX, 0, I_MAX, I_MAX, 0);
    rows.push_back(r);
    r.quad = mk_quad(I_MIN, I_MIN, I_MAX, I_MIN, I_MIN, I_MAX, I_MAX - 5, I_MAX);
    rows.push_back(r);
    r.quad = mk_quad(100, 200, 100 + ONE_Q, 200, 100, 200 + ONE_Q, 100 + ONE_Q, 201 + ONE_Q);
    rows.push_back(r);
    r.quad = mk_quad(-1, -1, 1, -1, -1, 1, 3, 3);
    rows.push_back(r);
    r.quad = mk_quad(0, 0, ONE_Q, ONE_Q, 2 * ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 5 * ONE_Q);
    rows.push_back(r);
    for (int i = 0; i < RANDOM_QUADS; i++) begin
      r.quad = random_quad();
      rows.push_back(r);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // each pass starts at a falling edge, so accepted transactions can follow back to back
    for (int i = 0; i < rows.size(); i++) begin
      quiet = (i >= 200 && i < 350);
      // hold off once until the pipeline has drained
      if (i == 500) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (matrix_q.size() != 0);
      end
      while (idle_now()) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= rows[i].quad;
      in_typed <= rows[i].typed;
      in_mat   <= rows[i].mat;
      do @(negedge clk); while (!in_fire);
    end
    in_valid <= 1'b0;

    while (matrix_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pwsq_pkg.sv
src/pwsq_front.sv
src/pwsq_fifo.sv
src/pwsq_back.sv
src/projective_warp_square_to_quad_top.sv
tb/projective_warp_square_to_quad_top_tb.sv
